### hw/rtl/iocs_pkg.sv
// Shared types and constants for the I/O range chunk splitter.
// Used by the front, queue, back and top-level modules; no dependencies.
package iocs_pkg;

	localparam int OFF_W  = 48;
	localparam int LEN_W  = 31;
	localparam int IDX_W  = 23;
	localparam int BOFF_W = 30;
	localparam int CFG_W  = 48;
	localparam int CIDX_W = 2;

	localparam logic [OFF_W-1:0] MIN_CHUNK   = 48'd33554432;
	localparam logic [OFF_W-1:0] RESET_CHUNK = 48'd67108864;
	localparam logic [LEN_W-1:0] MAX_LEN     = 31'd1073741824;

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS = OFF_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_VOLUME = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_CHUNK  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_RDONLY = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_RO    = 2'd2
	} status_t;

	// classified request handed from front to back
	typedef struct packed {
		status_t            status;
		logic [OFF_W-1:0]   start;
		logic [LEN_W-1:0]   len;
	} cmd_t;

endpackage

### hw/rtl/iocs_front.sv
// Front end: accepts request words, runs the snapshot and range checks.
// Uses iocs_pkg; feeds classified commands to iocs_queue.
module iocs_front (
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [iocs_pkg::OFF_W-1:0]  start_offset,
	input  logic [iocs_pkg::LEN_W-1:0]  request_length,
	input  logic [iocs_pkg::OFF_W-1:0]  volume_bytes,
	input  logic                        read_only,
	input  logic                        q_full,
	output logic                        push,
	output iocs_pkg::cmd_t              cmd
);

	logic [iocs_pkg::OFF_W:0] end_sum;
	logic                     too_long;
	logic                     past_end;
	logic                     is_ro;

	// end of request, formed one bit wider so it cannot wrap
	assign end_sum  = {1'b0, start_offset} + {{(iocs_pkg::OFF_W + 1 - iocs_pkg::LEN_W){1'b0}},
		request_length};
	assign too_long = request_length > iocs_pkg::MAX_LEN;
	assign past_end = end_sum > {1'b0, volume_bytes};
	assign is_ro    = func & read_only;

	// classify: snapshot check first, then range
	always_comb begin
		cmd.start = start_offset;
		cmd.len   = request_length;
		if (is_ro) begin
			cmd.status = iocs_pkg::ST_RO;
		end else if (too_long || past_end) begin
			cmd.status = iocs_pkg::ST_RANGE;
		end else begin
			cmd.status = iocs_pkg::ST_OK;
		end
	end

	assign in_stall = q_full;

	// an empty request that passes the checks is dropped here
	assign push = in_valid && !q_full &&
		!(cmd.status == iocs_pkg::ST_OK && request_length == '0);

endmodule

### hw/rtl/iocs_queue.sv
// Short command queue that decouples the front end from the splitter back end.
// Uses iocs_pkg for the command type and depth.
module iocs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  iocs_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output iocs_pkg::cmd_t  pop_cmd
);

	iocs_pkg::cmd_t           mem_q [iocs_pkg::Q_DEPTH];
	logic [iocs_pkg::Q_AW-1:0] wptr_q;
	logic [iocs_pkg::Q_AW-1:0] rptr_q;
	logic [iocs_pkg::Q_AW:0]   cnt_q;

	assign full    = cnt_q == (iocs_pkg::Q_AW + 1)'(iocs_pkg::Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_cmd = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/iocs_back.sv
// Back end: divides the start offset by the chunk size, then emits segments.
// Uses iocs_pkg; pulls commands from iocs_queue, drives the result register.
module iocs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [iocs_pkg::OFF_W-1:0]    csize,
	input  logic                          q_empty,
	input  iocs_pkg::cmd_t                q_cmd,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [iocs_pkg::IDX_W-1:0]    chunk_index,
	output logic [iocs_pkg::OFF_W-1:0]    offset_in_chunk,
	output logic [iocs_pkg::LEN_W-1:0]    segment_length,
	output logic [iocs_pkg::BOFF_W-1:0]   buffer_offset,
	output logic                          last
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_EMIT
	} bstate_t;

	bstate_t                        state_q;
	iocs_pkg::status_t              err_q;
	logic [iocs_pkg::OFF_W-1:0]     dq_q;    // dividend in, quotient / chunk index out
	logic [iocs_pkg::OFF_W-1:0]     rem_q;   // remainder, then offset in chunk
	logic [iocs_pkg::DCNT_W-1:0]    cnt_q;
	logic [iocs_pkg::LEN_W-1:0]     left_q;
	logic [iocs_pkg::BOFF_W-1:0]    boff_q;

	logic                           ovalid_q;
	iocs_pkg::status_t              ostat_q;
	logic [iocs_pkg::IDX_W-1:0]     oidx_q;
	logic [iocs_pkg::OFF_W-1:0]     ooff_q;
	logic [iocs_pkg::LEN_W-1:0]     olen_q;
	logic [iocs_pkg::BOFF_W-1:0]    oboff_q;
	logic                           olast_q;

	logic [iocs_pkg::OFF_W:0]       trial;
	logic                           ge;
	logic [iocs_pkg::OFF_W:0]       trial_sub;
	logic [iocs_pkg::OFF_W-1:0]     room;
	logic                           fits;
	logic [iocs_pkg::LEN_W-1:0]     take;
	logic                           out_free;

	// one restoring division step
	assign trial     = {rem_q, dq_q[iocs_pkg::OFF_W-1]};
	assign ge        = trial >= {1'b0, csize};
	assign trial_sub = trial - {1'b0, csize};

	// segment size: rest of the request or rest of the chunk
	assign room = csize - rem_q;
	assign fits = {{(iocs_pkg::OFF_W - iocs_pkg::LEN_W){1'b0}}, left_q} <= room;
	assign take = fits ? left_q : room[iocs_pkg::LEN_W-1:0];

	assign out_free = !ovalid_q || !out_stall;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;

	// sequencer, divider and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			err_q    <= iocs_pkg::ST_OK;
			dq_q     <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			left_q   <= '0;
			boff_q   <= '0;
			ovalid_q <= 1'b0;
			ostat_q  <= iocs_pkg::ST_OK;
			oidx_q   <= '0;
			ooff_q   <= '0;
			olen_q   <= '0;
			oboff_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (out_free) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						err_q  <= q_cmd.status;
						dq_q   <= q_cmd.start;
						rem_q  <= '0;
						cnt_q  <= '0;
						left_q <= q_cmd.len;
						boff_q <= '0;
						state_q <= (q_cmd.status == iocs_pkg::ST_OK) ? B_DIV : B_EMIT;
					end
				end
				B_DIV: begin
					rem_q <= ge ? trial_sub[iocs_pkg::OFF_W-1:0] : trial[iocs_pkg::OFF_W-1:0];
					dq_q  <= {dq_q[iocs_pkg::OFF_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == iocs_pkg::DCNT_W'(iocs_pkg::DIV_STEPS - 1)) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (err_q != iocs_pkg::ST_OK) begin
							// refused request: single zeroed word
							ostat_q <= err_q;
							oidx_q  <= '0;
							ooff_q  <= '0;
							olen_q  <= '0;
							oboff_q <= '0;
							olast_q <= 1'b1;
							state_q <= B_IDLE;
						end else begin
							ostat_q <= iocs_pkg::ST_OK;
							oidx_q  <= dq_q[iocs_pkg::IDX_W-1:0];
							ooff_q  <= rem_q;
							olen_q  <= take;
							oboff_q <= boff_q;
							olast_q <= fits;
							// later segments start on a chunk boundary
							left_q  <= left_q - take;
							boff_q  <= boff_q + take[iocs_pkg::BOFF_W-1:0];
							rem_q   <= '0;
							dq_q    <= dq_q + 1'b1;
							if (fits) begin
								state_q <= B_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = ovalid_q;
	assign status          = ostat_q;
	assign chunk_index     = oidx_q;
	assign offset_in_chunk = ooff_q;
	assign segment_length  = olen_q;
	assign buffer_offset   = oboff_q;
	assign last            = olast_q;

endmodule

### hw/rtl/io_range_chunk_splitter_top.sv
// Top level of the I/O range chunk splitter; uses iocs_pkg, iocs_front, iocs_queue, iocs_back.
// Flow: an accepted word is registered in the queue, the back end pops it when idle, and a
// restoring divide finds chunk index and offset, then one segment per cycle unless the
// output stalls. A refused request skips the divide and gives a single zeroed word.
// The back end pops a new request only when idle, after the last one has finished;
// input stalls only while the two-entry command queue is full. Reset (async, active low)
// clears control state and loads register defaults.
module io_range_chunk_splitter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [iocs_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [iocs_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [iocs_pkg::OFF_W-1:0]    start_offset,
	input  logic [iocs_pkg::LEN_W-1:0]    request_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [iocs_pkg::IDX_W-1:0]    chunk_index,
	output logic [iocs_pkg::OFF_W-1:0]    offset_in_chunk,
	output logic [iocs_pkg::LEN_W-1:0]    segment_length,
	output logic [iocs_pkg::BOFF_W-1:0]   buffer_offset,
	output logic                          last
);

	logic [iocs_pkg::OFF_W-1:0] volume_q;
	logic [iocs_pkg::OFF_W-1:0] csize_q;   // chunk size, floored at the minimum
	logic                       read_only_q;

	logic           push;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	iocs_pkg::cmd_t push_cmd;
	iocs_pkg::cmd_t pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q    <= '0;
			csize_q     <= iocs_pkg::RESET_CHUNK;
			read_only_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				iocs_pkg::CFG_VOLUME: volume_q <= cfg_wdata;
				iocs_pkg::CFG_CHUNK: begin
					csize_q <= (cfg_wdata < iocs_pkg::MIN_CHUNK) ? iocs_pkg::MIN_CHUNK : cfg_wdata;
				end
				iocs_pkg::CFG_RDONLY: read_only_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	iocs_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.start_offset   (start_offset),
		.request_length (request_length),
		.volume_bytes   (volume_q),
		.read_only      (read_only_q),
		.q_full         (q_full),
		.push           (push),
		.cmd            (push_cmd)
	);

	iocs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (pop_cmd)
	);

	iocs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.csize           (csize_q),
		.q_empty         (q_empty),
		.q_cmd           (pop_cmd),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.chunk_index     (chunk_index),
		.offset_in_chunk (offset_in_chunk),
		.segment_length  (segment_length),
		.buffer_offset   (buffer_offset),
		.last            (last)
	);

`ifndef NO_ASSERTIONS
	// a refused request is a single zeroed word
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != iocs_pkg::ST_OK |-> last && segment_length == '0)
		else $error("refused request word not single or not zeroed");

	// a passing segment is never empty
	a_seg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == iocs_pkg::ST_OK |-> segment_length != '0)
		else $error("empty segment emitted");

	// every segment but the final one runs to the end of its chunk
	a_seg_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == iocs_pkg::ST_OK && !last |->
		({1'b0, offset_in_chunk} + {{(iocs_pkg::OFF_W + 1 - iocs_pkg::LEN_W){1'b0}},
		segment_length}) == {1'b0, csize_q})
		else $error("non-final segment does not end on a chunk boundary");
`endif

endmodule
